### src/assert_macros.svh
// Assertion macros used by the top level of the Kalman tracker.
// No dependencies; each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define KF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, inactive during reset.
`define KF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### src/kf_pkg.sv
// Types, memory map and microcode decode for the Kalman tracker.
// No dependencies; used by the interfaces, the ALU and the top level.
package kf_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned MEM_DEPTH  = 64;
  localparam int unsigned NSTATE     = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POS      = 8'd2;

  // Memory map (sources are 7 bits: bit 6 picks a non-memory operand)
  localparam logic [6:0] A_ST  = 7'd0;
  localparam logic [6:0] A_COV = 7'd4;
  localparam logic [6:0] A_Y0  = 7'd20;
  localparam logic [6:0] A_Y1  = 7'd21;
  localparam logic [6:0] A_S00 = 7'd22;
  localparam logic [6:0] A_S01 = 7'd23;
  localparam logic [6:0] A_S10 = 7'd24;
  localparam logic [6:0] A_S11 = 7'd25;
  localparam logic [6:0] A_T0  = 7'd26;
  localparam logic [6:0] A_T1  = 7'd27;
  localparam logic [6:0] A_DET = 7'd28;
  localparam logic [6:0] A_SI  = 7'd29;
  localparam logic [6:0] A_NT  = 7'd33;
  localparam logic [6:0] A_K   = 7'd34;
  localparam logic [6:0] A_XC  = 7'd42;
  localparam logic [6:0] A_PC  = 7'd46;
  localparam logic [6:0] A_AM  = 7'd20;  // reuses the correction scratch

  localparam logic [6:0] SRC_MX = 7'h40;
  localparam logic [6:0] SRC_MY = 7'h41;
  localparam logic [6:0] SRC_RN = 7'h42;
  localparam logic [6:0] SRC_QN = 7'h43;

  typedef enum logic [2:0] {
    OP_MOV, OP_ADD, OP_ADDZ, OP_SUB, OP_DET, OP_NEG, OP_MUL, OP_DIV
  } op_e;

  typedef enum logic [3:0] {
    PH_PRE, PH_INV, PH_GAIN, PH_XC, PH_PC, PH_CPX, PH_CPP, PH_PST, PH_AM, PH_COV
  } ph_e;

  typedef struct packed {
    logic       en;
    op_e        op;
    logic [6:0] src_a;
    logic [6:0] src_b;
    logic [5:0] dst;
  } instr_t;

  typedef struct packed {
    logic start;
    op_e  op;
    logic zp;
  } alu_req_t;

  function automatic logic [6:0] mat(logic [6:0] base, logic [1:0] r, logic [1:0] c);
    return base + 7'({r, c});
  endfunction

  function automatic logic [6:0] vec(logic [6:0] base, logic [1:0] i);
    return base + 7'(i);
  endfunction

  function automatic instr_t mk(logic en, op_e op, logic [6:0] sa, logic [6:0] sb,
                                logic [6:0] d);
    instr_t r;
    r.en    = en;
    r.op    = op;
    r.src_a = sa;
    r.src_b = sb;
    r.dst   = d[5:0];
    return r;
  endfunction

  function automatic logic [3:0] last_s(ph_e ph);
    case (ph)
      PH_PRE:  return 4'd8;
      PH_INV:  return 4'd5;
      PH_GAIN: return 4'd2;
      PH_XC,
      PH_PC,
      PH_PST:  return 4'd3;
      PH_AM,
      PH_COV:  return 4'd1;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [1:0] last_a(ph_e ph);
    case (ph)
      PH_GAIN, PH_XC, PH_PC, PH_CPX, PH_CPP, PH_COV: return 2'd3;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] last_b(ph_e ph);
    case (ph)
      PH_GAIN: return 2'd1;
      PH_PC, PH_CPP, PH_AM, PH_COV: return 2'd3;
      default: return 2'd0;
    endcase
  endfunction

  // One microcode step for (phase, row a, column b, step s).
  function automatic instr_t decode(ph_e ph, logic [1:0] a, logic [1:0] b,
                                    logic [3:0] s, logic sing);
    instr_t     ins;
    logic [6:0] lo;
    logic [6:0] hi;
    ins = mk(1'b0, OP_MOV, A_T0, A_T0, A_T0);
    lo  = a[1] ? mat(A_PC, a, b) : mat(A_AM, a, b);
    hi  = a[1] ? mat(A_PC, a, {1'b1, b[0]}) : mat(A_AM, a, {1'b1, b[0]});
    case (ph)
      PH_PRE: begin
        case (s)
          4'd0: ins = mk(1'b1, OP_SUB, SRC_MX, vec(A_ST, 2'd0), A_Y0);
          4'd1: ins = mk(1'b1, OP_SUB, SRC_MY, vec(A_ST, 2'd1), A_Y1);
          4'd2: ins = mk(1'b1, OP_ADD, mat(A_COV, 2'd0, 2'd0), SRC_RN, A_S00);
          4'd3: ins = mk(1'b1, OP_MOV, mat(A_COV, 2'd0, 2'd1), A_T0, A_S01);
          4'd4: ins = mk(1'b1, OP_MOV, mat(A_COV, 2'd1, 2'd0), A_T0, A_S10);
          4'd5: ins = mk(1'b1, OP_ADD, mat(A_COV, 2'd1, 2'd1), SRC_RN, A_S11);
          4'd6: ins = mk(1'b1, OP_MUL, A_S00, A_S11, A_T0);
          4'd7: ins = mk(1'b1, OP_MUL, A_S01, A_S10, A_T1);
          4'd8: ins = mk(1'b1, OP_DET, A_T0, A_T1, A_DET);
          default: ins = mk(1'b0, OP_MOV, A_T0, A_T0, A_T0);
        endcase
      end
      PH_INV: begin
        case (s)
          4'd0: ins = mk(!sing, OP_DIV, A_S11, A_DET, mat(A_SI, 2'd0, 2'd0) - 7'd0);
          4'd1: ins = mk(!sing, OP_NEG, A_S01, A_T0, A_NT);
          4'd2: ins = mk(!sing, OP_DIV, A_NT, A_DET, A_SI + 7'd1);
          4'd3: ins = mk(!sing, OP_NEG, A_S10, A_T0, A_NT);
          4'd4: ins = mk(!sing, OP_DIV, A_NT, A_DET, A_SI + 7'd2);
          4'd5: ins = mk(!sing, OP_DIV, A_S00, A_DET, A_SI + 7'd3);
          default: ins = mk(1'b0, OP_MOV, A_T0, A_T0, A_T0);
        endcase
      end
      PH_GAIN: begin
        case (s)
          4'd0: ins = mk(!sing, OP_MUL, mat(A_COV, a, 2'd0), A_SI + 7'({1'b0, b[0]}),
                         A_T0);
          4'd1: ins = mk(!sing, OP_MUL, mat(A_COV, a, 2'd1), A_SI + 7'({1'b1, b[0]}),
                         A_T1);
          default: ins = mk(!sing, OP_ADD, A_T0, A_T1, A_K + 7'({a, b[0]}));
        endcase
      end
      PH_XC: begin
        case (s)
          4'd0: ins = mk(!sing, OP_MUL, A_K + 7'({a, 1'b0}), A_Y0, A_T0);
          4'd1: ins = mk(!sing, OP_MUL, A_K + 7'({a, 1'b1}), A_Y1, A_T1);
          4'd2: ins = mk(!sing, OP_ADD, A_T0, A_T1, A_T0);
          default: ins = mk(!sing, OP_ADD, vec(A_ST, a), A_T0, vec(A_XC, a));
        endcase
      end
      PH_PC: begin
        case (s)
          4'd0: ins = mk(!sing, OP_MUL, A_K + 7'({a, 1'b0}), mat(A_COV, 2'd0, b), A_T0);
          4'd1: ins = mk(!sing, OP_MUL, A_K + 7'({a, 1'b1}), mat(A_COV, 2'd1, b), A_T1);
          4'd2: ins = mk(!sing, OP_ADD, A_T0, A_T1, A_T0);
          default: ins = mk(!sing, OP_SUB, mat(A_COV, a, b), A_T0, mat(A_PC, a, b));
        endcase
      end
      PH_CPX: ins = mk(sing, OP_MOV, vec(A_ST, a), A_T0, vec(A_XC, a));
      PH_CPP: ins = mk(sing, OP_MOV, mat(A_COV, a, b), A_T0, mat(A_PC, a, b));
      PH_PST: begin
        case (s)
          4'd0: ins = mk(1'b1, OP_ADDZ, vec(A_XC, 2'd0), vec(A_XC, 2'd2), vec(A_ST, 2'd0));
          4'd1: ins = mk(1'b1, OP_ADDZ, vec(A_XC, 2'd1), vec(A_XC, 2'd3), vec(A_ST, 2'd1));
          4'd2: ins = mk(1'b1, OP_MOV, vec(A_XC, 2'd2), A_T0, vec(A_ST, 2'd2));
          default: ins = mk(1'b1, OP_MOV, vec(A_XC, 2'd3), A_T0, vec(A_ST, 2'd3));
        endcase
      end
      PH_AM: begin
        if (s == 4'd0) begin
          ins = mk(1'b1, OP_ADDZ, mat(A_PC, 2'd0, b), mat(A_PC, 2'd2, b), mat(A_AM, 2'd0, b));
        end else begin
          ins = mk(1'b1, OP_ADDZ, mat(A_PC, 2'd1, b), mat(A_PC, 2'd3, b), mat(A_AM, 2'd1, b));
        end
      end
      PH_COV: begin
        if (s != 4'd0) begin
          ins = mk(a == b, OP_ADD, mat(A_COV, a, b), SRC_QN, mat(A_COV, a, b));
        end else if (!b[1]) begin
          ins = mk(1'b1, OP_ADDZ, lo, hi, mat(A_COV, a, b));
        end else begin
          ins = mk(1'b1, OP_MOV, lo, A_T0, mat(A_COV, a, b));
        end
      end
      default: ins = mk(1'b0, OP_MOV, A_T0, A_T0, A_T0);
    endcase
    return ins;
  endfunction

endpackage

### src/kf_if.sv
// Handshake channel interfaces of the Kalman tracker: measurement, estimate, config.
// Depends on kf_pkg for the configuration field widths.
interface kf_meas_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] meas_x;
  logic signed [31:0] meas_y;
  modport source (output valid, meas_x, meas_y, input ready);
  modport sink   (input valid, meas_x, meas_y, output ready);
endinterface

interface kf_est_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_pos_x;
  logic signed [31:0] est_pos_y;
  logic signed [31:0] est_vel_x;
  logic signed [31:0] est_vel_y;
  logic               singular;
  modport source (output valid, est_pos_x, est_pos_y, est_vel_x, est_vel_y, singular,
                  input ready);
  modport sink   (input valid, est_pos_x, est_pos_y, est_vel_x, est_vel_y, singular,
                  output ready);
endinterface

interface kf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [kf_pkg::CFG_IDX_W-1:0]    index;
  logic [kf_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/kf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kf_ram #(
  parameter int unsigned DW    = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### src/kf_alu.sv
// Shared saturating fixed-point ALU: add/sub/neg, split multiply,
// bit-serial restoring divide. Depends on kf_pkg.
module kf_alu #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kf_pkg::alu_req_t      req_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic                  done_o,
  output logic signed [W-1:0]   res_o
);
  import kf_pkg::*;

  localparam int unsigned H  = (W + 1) / 2;
  localparam int unsigned QW = W + F;
  localparam int unsigned CW = $clog2(QW + 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] LIMP = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [2*W-1:0] LIMN = LIMP + (2*W)'(1);

  typedef enum logic [2:0] {AS_IDLE, AS_MUL1, AS_MUL2, AS_MULF, AS_DIV, AS_DIVF} ast_e;

  function automatic logic signed [W-1:0] sat1(logic [W:0] s);
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] fromsign(logic neg, logic [2*W-1:0] m);
    logic [2*W-1:0] nm;
    nm = ~m + (2*W)'(1);
    if (neg) return (m > LIMN) ? WMIN : nm[W-1:0];
    return (m > LIMP) ? WMAX : m[W-1:0];
  endfunction

  ast_e           st_q;
  logic           neg_q;
  logic [W-1:0]   ua_q, ub_q;
  logic [2*W-1:0] prod_q;
  logic [QW-1:0]  dv_q, quo_q;
  logic [W-1:0]   rem_q;
  logic [CW-1:0]  cnt_q;
  logic signed [W-1:0] res_q;
  logic           done_q;

  logic [W-1:0]   ma, mb;
  logic [W:0]     sum_add, sum_sub, sum_neg;
  logic [H-1:0]   part;
  logic [W+H-1:0] mulp;
  logic [W:0]     r2, rsub;
  logic           ge;

  assign ma      = a_i[W-1] ? W'(~a_i + 1'b1) : W'(a_i);
  assign mb      = b_i[W-1] ? W'(~b_i + 1'b1) : W'(b_i);
  assign sum_add = {a_i[W-1], a_i} + {b_i[W-1], b_i};
  assign sum_sub = {a_i[W-1], a_i} - {b_i[W-1], b_i};
  assign sum_neg = (W+1)'(0) - {a_i[W-1], a_i};
  assign part    = (st_q == AS_MUL1) ? ub_q[H-1:0] : H'(ub_q[W-1:H]);
  assign mulp    = (W+H)'(ua_q) * (W+H)'(part);
  assign r2      = {rem_q, dv_q[QW-1]};
  assign rsub    = r2 - {1'b0, ub_q};
  assign ge      = r2 >= {1'b0, ub_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= AS_IDLE;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      ua_q   <= '0;
      ub_q   <= '0;
      prod_q <= '0;
      dv_q   <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        AS_IDLE: begin
          if (req_i.start) begin
            neg_q  <= a_i[W-1] ^ b_i[W-1];
            ua_q   <= ma;
            ub_q   <= mb;
            done_q <= !(req_i.op == OP_MUL || req_i.op == OP_DIV);
            case (req_i.op)
              OP_MOV:  res_q <= a_i;
              OP_ADD:  res_q <= sat1(sum_add);
              OP_ADDZ: res_q <= req_i.zp ? b_i : sat1(sum_add);
              OP_SUB,
              OP_DET:  res_q <= sat1(sum_sub);
              OP_NEG:  res_q <= sat1(sum_neg);
              OP_MUL:  st_q  <= AS_MUL1;
              OP_DIV: begin
                dv_q  <= {ma, {F{1'b0}}};
                rem_q <= '0;
                cnt_q <= '0;
                st_q  <= AS_DIV;
              end
              default: res_q <= a_i;
            endcase
          end
        end
        AS_MUL1: begin
          prod_q <= (2*W)'(mulp);
          st_q   <= AS_MUL2;
        end
        AS_MUL2: begin
          prod_q <= prod_q + ((2*W)'(mulp) << H);
          st_q   <= AS_MULF;
        end
        AS_MULF: begin
          res_q  <= fromsign(neg_q, prod_q >> F);
          done_q <= 1'b1;
          st_q   <= AS_IDLE;
        end
        AS_DIV: begin
          rem_q <= ge ? rsub[W-1:0] : r2[W-1:0];
          quo_q <= {quo_q[QW-2:0], ge};
          dv_q  <= dv_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(QW - 1)) st_q <= AS_DIVF;
        end
        AS_DIVF: begin
          res_q  <= fromsign(neg_q, (2*W)'(quo_q));
          done_q <= 1'b1;
          st_q   <= AS_IDLE;
        end
        default: st_q <= AS_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

### src/kalman_filter_4state_2meas.sv
// Top level of the 2D constant-velocity Kalman tracker: microcode sequencer,
// state memory with reset-valid bits, operand fetch and channel handling.
// Depends on kf_pkg, kf_if, kf_ram, kf_alu and assert_macros.svh.
//
//  channel  dir  payload                                        transfer
//  cfg_i    in   index, data (17 b)                             valid & ready
//  meas_i   in   meas_x, meas_y (s32)                           valid & ready
//  est_o    out  est_pos_x/y, est_vel_x/y (s32), singular       valid & ready
//
// One item at a time. The cost of an item is set by the single ALU and the
// single memory read port: each step reads operand A, then operand B, then
// starts the ALU and waits for its result; a multiply runs as two partial
// products and a divide is bit-serial. A singular item costs less.
// Reset restores the state through valid bits, no clearing pass is needed.
// A finished estimate waits in the output register; a stalled est_o only
// holds the sequencer in its final step, meas_i is ready again once it drains.
`include "assert_macros.svh"

module kalman_filter_4state_2meas #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned WORD_WIDTH = 32
) (
  input logic      clk_i,
  input logic      rst_ni,
  kf_cfg_if.sink   cfg_i,
  kf_meas_if.sink  meas_i,
  kf_est_if.source est_o
);
  import kf_pkg::*;

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam logic signed [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;

  typedef enum logic [2:0] {ST_IDLE, ST_RDA, ST_RDB, ST_GO, ST_EXEC, ST_DONE} st_e;

  // Saturate a 32-bit input to the working word.
  function automatic logic signed [W-1:0] in_sat(logic signed [31:0] v);
    logic signed [31:0] hi;
    hi = v >>> (W - 1);
    if (hi == '0 || hi == '1) return W'(v);
    return v[31] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  // Saturate the working word to the 32-bit output.
  function automatic logic signed [31:0] out_sat(logic signed [W-1:0] v);
    logic signed [W-1:0] hi;
    hi = v >>> 31;
    if (hi == '0 || hi == '1) return 32'(v);
    return v[W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // Configuration
  logic [CFG_DATA_W-1:0] rn_q, qn_q;
  logic                  zp_q;

  // Sequencer and datapath control
  st_e                 st_q;
  ph_e                 ph_q, ph_d;
  logic [1:0]          ia_q, ia_d, ib_q, ib_d;
  logic [3:0]          is_q, is_d;
  logic                seq_end;
  logic                sing_q;
  logic [NSTATE-1:0]   vld_q;
  logic [6:0]          rsrc_q;
  logic signed [W-1:0] opa_q;
  logic signed [W-1:0] ew_q [4];
  logic signed [31:0]  out_q [4];
  logic                osing_q, ov_q;
  logic signed [31:0]  mx_q, my_q;

  instr_t              instr;
  logic signed [W-1:0] opnd;
  logic [3:0]          ci;
  logic                diag;
  logic [AW-1:0]       raddr;
  logic [W-1:0]        rdata;
  logic                we;
  alu_req_t            alu_req;
  logic                alu_done;
  logic signed [W-1:0] alu_res;
  logic                meas_fire, est_fire, cfg_fire;

  assign meas_fire = meas_i.valid && meas_i.ready;
  assign est_fire  = est_o.valid && est_o.ready;
  assign cfg_fire  = cfg_i.valid && cfg_i.ready;

  assign instr = decode(ph_q, ia_q, ib_q, is_q, sing_q);

  // Step counters: s innermost, then column, row, phase.
  always_comb begin
    ph_d    = ph_q;
    ia_d    = ia_q;
    ib_d    = ib_q;
    is_d    = is_q;
    seq_end = 1'b0;
    if (is_q != last_s(ph_q)) begin
      is_d = is_q + 1'b1;
    end else begin
      is_d = '0;
      if (ib_q != last_b(ph_q)) begin
        ib_d = ib_q + 1'b1;
      end else begin
        ib_d = '0;
        if (ia_q != last_a(ph_q)) begin
          ia_d = ia_q + 1'b1;
        end else begin
          ia_d = '0;
          if (ph_q == PH_COV) begin
            seq_end = 1'b1;
            ph_d    = PH_PRE;
          end else begin
            ph_d = ph_e'(ph_q + 1'b1);
          end
        end
      end
    end
  end

  // Operand fetch: special sources, then state entries never written since
  // reset read back as their reset value (identity on the covariance diagonal).
  assign ci   = 4'(rsrc_q[4:0] - 5'(A_COV));
  assign diag = (rsrc_q[4:0] >= 5'(A_COV)) && (ci[1:0] == ci[3:2]);

  always_comb begin
    opnd = rdata;
    if (rsrc_q[6]) begin
      case (rsrc_q)
        SRC_MX:  opnd = in_sat(mx_q);
        SRC_MY:  opnd = in_sat(my_q);
        SRC_RN:  opnd = W'(rn_q);
        SRC_QN:  opnd = W'(qn_q);
        default: opnd = '0;
      endcase
    end else if (rsrc_q[5:0] < 6'(NSTATE) && !vld_q[rsrc_q[4:0]]) begin
      opnd = diag ? ONE : '0;
    end
  end

  assign raddr = (st_q == ST_RDA) ? instr.src_a[AW-1:0] : instr.src_b[AW-1:0];
  assign we    = (st_q == ST_EXEC) && alu_done;

  kf_ram #(
    .DW    (W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (instr.dst[AW-1:0]),
    .wdata_i (alu_res),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign alu_req.start = (st_q == ST_GO);
  assign alu_req.op    = instr.op;
  assign alu_req.zp    = zp_q;

  kf_alu #(
    .W (W),
    .F (FRAC_BITS)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (opa_q),
    .b_i    (opnd),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // Configuration registers; writes land at any time, unknown indexes dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rn_q <= CFG_DATA_W'(33);
      qn_q <= CFG_DATA_W'(7);
      zp_q <= 1'b1;
    end else if (cfg_fire) begin
      case (cfg_i.index)
        CFG_MEAS_NOISE:    rn_q <= cfg_i.data;
        CFG_PROCESS_NOISE: qn_q <= cfg_i.data;
        CFG_ZERO_POS:      zp_q <= cfg_i.data[0];
        default:           ;
      endcase
    end
  end

  // Sequencer: read A, read B, start ALU, wait and write back, then next step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      ph_q    <= PH_PRE;
      ia_q    <= '0;
      ib_q    <= '0;
      is_q    <= '0;
      sing_q  <= 1'b0;
      vld_q   <= '0;
      rsrc_q  <= '0;
      opa_q   <= '0;
      ov_q    <= 1'b0;
      osing_q <= 1'b0;
      mx_q    <= '0;
      my_q    <= '0;
      for (int i = 0; i < 4; i++) begin
        ew_q[i]  <= '0;
        out_q[i] <= '0;
      end
    end else begin
      // In the final step the output register is reloaded instead.
      if (est_fire && st_q != ST_DONE) ov_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (meas_fire) begin
            mx_q   <= meas_i.meas_x;
            my_q   <= meas_i.meas_y;
            sing_q <= 1'b0;
            st_q   <= ST_RDA;
          end
        end
        ST_RDA: begin
          if (instr.en) begin
            rsrc_q <= instr.src_a;
            st_q   <= ST_RDB;
          end else begin
            ph_q <= ph_d;
            ia_q <= ia_d;
            ib_q <= ib_d;
            is_q <= is_d;
            if (seq_end) st_q <= ST_DONE;
          end
        end
        ST_RDB: begin
          opa_q  <= opnd;
          rsrc_q <= instr.src_b;
          st_q   <= ST_GO;
        end
        ST_GO: st_q <= ST_EXEC;
        ST_EXEC: begin
          if (alu_done) begin
            if (instr.dst < 6'(NSTATE)) vld_q[instr.dst[4:0]] <= 1'b1;
            if (instr.dst < 6'(A_COV)) ew_q[instr.dst[1:0]] <= alu_res;
            if (instr.op == OP_DET) sing_q <= (alu_res == '0);
            ph_q <= ph_d;
            ia_q <= ia_d;
            ib_q <= ib_d;
            is_q <= is_d;
            st_q <= seq_end ? ST_DONE : ST_RDA;
          end
        end
        ST_DONE: begin
          // Hand over once the output register is free or draining now.
          if (!ov_q || est_o.ready) begin
            for (int i = 0; i < 4; i++) out_q[i] <= out_sat(ew_q[i]);
            osing_q <= sing_q;
            ov_q    <= 1'b1;
            st_q    <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign cfg_i.ready     = 1'b1;
  assign meas_i.ready    = (st_q == ST_IDLE);
  assign est_o.valid     = ov_q;
  assign est_o.est_pos_x = out_q[0];
  assign est_o.est_pos_y = out_q[1];
  assign est_o.est_vel_x = out_q[2];
  assign est_o.est_vel_y = out_q[3];
  assign est_o.singular  = osing_q;

  `KF_ASSERT_IMP(a_done_in_exec, alu_done, st_q == ST_EXEC, "ALU result outside execute")
  `KF_ASSERT_NXT(a_item_starts, meas_fire, st_q == ST_RDA && ph_q == PH_PRE, "item did not start")
  `KF_ASSERT_IMP(a_inv_nonsing, st_q == ST_GO && ph_q == PH_INV, !sing_q, "inverse on zero det")
endmodule
